// ----- design/tsh_pkg.sv -----
// ----------------------------------------------------------------------------
// tsh_pkg
// Shared types and constants of the tombstone hash map: slot entry layout,
// slot state codes, action and result codes, and the hash multiplier.
// ----------------------------------------------------------------------------
package tsh_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 32768;
  localparam int unsigned PROBE_LIMIT_DEF = 512;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_UPLOAD = 2'd3;

  localparam logic [1:0] RES_OK   = 2'd0;
  localparam logic [1:0] RES_MISS = 2'd1;
  localparam logic [1:0] RES_FULL = 2'd2;
  localparam logic [1:0] RES_KEY0 = 2'd3;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_LIVE  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_state_e;

  typedef struct packed {
    slot_state_e status;
    logic [31:0] key;
    logic [31:0] handle;
    logic [31:0] uploads;
  } slot_entry_t;

endpackage

// ----- design/tombstone_hash_map.sv -----
// ----------------------------------------------------------------------------
// tombstone_hash_map
// A key-to-handle map in an open-addressed table with linear probing over a
// window of PROBE_LIMIT slots and tombstones for removed entries. After reset
// the block sweeps the slot memory, marking every slot empty, and accepts no
// transfer until that is done. One action is handled at a time: after its
// acceptance the key is hashed to its home slot, then 1 up to PROBE_LIMIT
// slots are probed, and the result is loaded into the output register before
// the next action can be accepted. The probe reads one slot per cycle from
// the single read port of the slot memory. A table size that is not a power
// of two needs an extra reduction of the hash to a slot index. An action with
// key zero skips the hash and the probe. A new action is accepted while the
// previous result still waits in the output register.
// ----------------------------------------------------------------------------
module tombstone_hash_map #(
  parameter int unsigned TABLE_SLOTS = tsh_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned PROBE_LIMIT = tsh_pkg::PROBE_LIMIT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action [1:0], key [33:2], handle [65:34], zero fill [71:66]
  input  logic [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status [1:0], found_handle [33:2], upload_count [65:34],
  // live_entries [81:66], tombstones [97:82], full_failures [129:98],
  // dropped_unused [161:130], zero fill [167:162]
  output logic [167:0] m_axis_tdata
);
  import tsh_pkg::*;

  localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int unsigned PROBE_W = $clog2(PROBE_LIMIT + 1);
  localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [PROBE_W-1:0] PROBE_LAST = PROBE_W'(PROBE_LIMIT - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_PROBE  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [SLOT_W-1:0]  clr_q, clr_d;
  logic [SLOT_W-1:0]  slot_q, slot_d, slot_nx;
  logic [SLOT_W-1:0]  tomb_slot_q, tomb_slot_d;
  logic               tomb_vld_q, tomb_vld_d;
  logic [PROBE_W-1:0] probe_q, probe_d;
  logic [1:0]         act_q, act_d;
  logic [31:0]        key_q, key_d;
  logic [31:0]        hdl_q, hdl_d;
  logic [1:0]         res_st_q, res_st_d;
  logic [31:0]        res_fh_q, res_fh_d;
  logic [31:0]        res_up_q, res_up_d;
  logic [15:0]        live_q, live_d;
  logic [15:0]        tomb_q, tomb_d;
  logic [31:0]        full_q, full_d;
  logic [31:0]        drop_q, drop_d;
  logic               out_vld_q, out_vld_d;
  logic [167:0]       out_dat_q, out_dat_d;

  logic               in_xfer;
  logic               hash_start;
  logic               hash_done;
  logic [SLOT_W-1:0]  hash_home;
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [SLOT_W-1:0]  ram_raddr;
  slot_entry_t        ram_wdata;
  slot_entry_t        rd;
  logic               hit, is_empty, is_tomb, is_last, have_tomb;
  logic [SLOT_W-1:0]  fill_slot;
  logic [31:0]        up_inc;
  slot_entry_t        fill_entry;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign hash_start    = in_xfer && (s_axis_tdata[33:2] != 32'd0);

  assign slot_nx   = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
  assign hit       = (rd.status == ST_LIVE) && (rd.key == key_q);
  assign is_empty  = (rd.status == ST_EMPTY);
  assign is_tomb   = (rd.status == ST_TOMB);
  assign is_last   = (probe_q == PROBE_LAST);
  assign have_tomb = tomb_vld_q || is_tomb;
  assign fill_slot = tomb_vld_q ? tomb_slot_q : slot_q;
  assign up_inc    = (rd.uploads == SAT32) ? rd.uploads : rd.uploads + 32'd1;
  assign fill_entry = '{status: ST_LIVE, key: key_q, handle: hdl_q, uploads: 32'd0};

  assign ram_raddr = (state_q == S_HASH) ? hash_home : slot_nx;

  tsh_hash #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (s_axis_tdata[33:2]),
    .done_o  (hash_done),
    .home_o  (hash_home)
  );

  tsh_slot_ram #(
    .DEPTH  (TABLE_SLOTS),
    .ADDR_W (SLOT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    slot_d      = slot_q;
    tomb_slot_d = tomb_slot_q;
    tomb_vld_d  = tomb_vld_q;
    probe_d     = probe_q;
    act_d       = act_q;
    key_d       = key_q;
    hdl_d       = hdl_q;
    res_st_d    = res_st_q;
    res_fh_d    = res_fh_q;
    res_up_d    = res_up_q;
    live_d      = live_q;
    tomb_d      = tomb_q;
    full_d      = full_q;
    drop_d      = drop_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_dat_d   = out_dat_q;
    ram_we      = 1'b0;
    ram_waddr   = slot_q;
    ram_wdata   = fill_entry;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '{status: ST_EMPTY, key: 32'd0, handle: 32'd0, uploads: 32'd0};
        clr_d     = clr_q + 1'b1;
        if (clr_q == SLOT_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          act_d = s_axis_tdata[1:0];
          key_d = s_axis_tdata[33:2];
          hdl_d = s_axis_tdata[65:34];
          if (s_axis_tdata[33:2] == 32'd0) begin
            res_st_d = RES_KEY0;
            res_fh_d = 32'd0;
            res_up_d = 32'd0;
            state_d  = S_RESULT;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          slot_d     = hash_home;
          probe_d    = '0;
          tomb_vld_d = 1'b0;
          state_d    = S_PROBE;
        end
      end
      S_PROBE: begin
        res_st_d = RES_OK;
        res_fh_d = 32'd0;
        res_up_d = 32'd0;
        priority if (hit) begin
          state_d = S_RESULT;
          unique case (act_q)
            ACT_INSERT: begin
              ram_we = 1'b1;
            end
            ACT_LOOKUP: begin
              res_fh_d = rd.handle;
              res_up_d = rd.uploads;
            end
            ACT_REMOVE: begin
              ram_we    = 1'b1;
              ram_wdata = '{status: ST_TOMB, key: rd.key, handle: 32'd0, uploads: 32'd0};
              res_fh_d  = rd.handle;
              res_up_d  = rd.uploads;
              live_d    = live_q - 16'd1;
              tomb_d    = tomb_q + 16'd1;
              if (rd.uploads == 32'd0 && drop_q != SAT32) begin
                drop_d = drop_q + 32'd1;
              end
            end
            ACT_UPLOAD: begin
              ram_we    = 1'b1;
              ram_wdata = '{status: ST_LIVE, key: rd.key, handle: rd.handle, uploads: up_inc};
              res_fh_d  = rd.handle;
              res_up_d  = up_inc;
            end
            default: begin
            end
          endcase
        end else if (is_empty || is_last) begin
          state_d = S_RESULT;
          if (act_q != ACT_INSERT) begin
            res_st_d = RES_MISS;
          end else if (have_tomb) begin
            ram_we    = 1'b1;
            ram_waddr = fill_slot;
            live_d    = live_q + 16'd1;
            tomb_d    = tomb_q - 16'd1;
          end else if (is_empty) begin
            ram_we = 1'b1;
            live_d = live_q + 16'd1;
          end else begin
            res_st_d = RES_FULL;
            if (full_q != SAT32) begin
              full_d = full_q + 32'd1;
            end
          end
        end else begin
          if (is_tomb && !tomb_vld_q) begin
            tomb_vld_d  = 1'b1;
            tomb_slot_d = slot_q;
          end
          slot_d  = slot_nx;
          probe_d = probe_q + 1'b1;
        end
      end
      S_RESULT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          out_dat_d = {6'd0, drop_q, full_q, tomb_q, live_q, res_up_q, res_fh_q, res_st_q};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      live_q    <= '0;
      tomb_q    <= '0;
      full_q    <= '0;
      drop_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      live_q    <= live_d;
      tomb_q    <= tomb_d;
      full_q    <= full_d;
      drop_q    <= drop_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    tomb_slot_q <= tomb_slot_d;
    tomb_vld_q  <= tomb_vld_d;
    probe_q     <= probe_d;
    act_q       <= act_d;
    key_q       <= key_d;
    hdl_q       <= hdl_d;
    res_st_q    <= res_st_d;
    res_fh_q    <= res_fh_d;
    res_up_q    <= res_up_d;
    out_dat_q   <= out_dat_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_dat_q;

`ifndef SYNTHESIS
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_PROBE || state_q == S_CLEAR))
    else $error("Slot memory written outside the clear sweep or a probe.");

  a_probe_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (probe_q <= PROBE_LAST))
    else $error("Probe ran past the probe window.");

  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tdata[33:2] == 32'd0) |=> (state_q == S_RESULT && res_st_q == RES_KEY0))
    else $error("Key zero transfer did not go straight to its result.");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && (!out_vld_q || m_axis_tready)) |=> (out_vld_q && state_q == S_IDLE))
    else $error("Result was not loaded into the output register.");
`endif

endmodule

// ----- design/tsh_hash.sv -----
// ----------------------------------------------------------------------------
// tsh_hash
// Home slot unit: multiplies the shifted key by the hash constant, then
// reduces the 32-bit product to a slot index, by masking for a power-of-two
// table and otherwise by a reciprocal multiplication, a multiply back and one
// compare and subtract.
// ----------------------------------------------------------------------------
module tsh_hash #(
  parameter int unsigned TABLE_SLOTS = tsh_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned SLOT_W      = $clog2(TABLE_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [31:0]       key_i,
  output logic              done_o,
  output logic [SLOT_W-1:0] home_o
);
  import tsh_pkg::*;

  localparam bit          IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam logic [31:0] SLOTS_C = 32'(TABLE_SLOTS);
  localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));

  logic        busy_q;
  logic        done_q;
  logic [31:0] prod_d, prod_q;
  logic [63:0] recip_prod;
  logic [31:0] quot_q, back_q, rem_q, rem_fix;
  logic [1:0]  step_q;

  // The estimated quotient is at most one below the true one, so a single
  // compare and subtract completes the remainder.
  assign prod_d     = {4'd0, key_i[31:4]} * HASH_MULT;
  assign recip_prod = 64'(prod_q) * 64'(RECIP);
  assign rem_fix    = (rem_q >= SLOTS_C) ? (rem_q - SLOTS_C) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (IS_POW2 || step_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod_d;
      step_q <= 2'd0;
    end else if (busy_q && !IS_POW2) begin
      quot_q <= recip_prod[63:32];
      back_q <= quot_q * SLOTS_C;
      rem_q  <= prod_q - back_q;
      step_q <= step_q + 2'd1;
    end
  end

  assign done_o = done_q;
  assign home_o = IS_POW2 ? prod_q[SLOT_W-1:0] : rem_fix[SLOT_W-1:0];

endmodule

// ----- design/tsh_slot_ram.sv -----
// ----------------------------------------------------------------------------
// tsh_slot_ram
// Slot table storage: one write port and one read port with a registered
// read, one entry holding slot state, key, handle and upload count.
// ----------------------------------------------------------------------------
module tsh_slot_ram #(
  parameter int unsigned DEPTH  = tsh_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  tsh_pkg::slot_entry_t wdata_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output tsh_pkg::slot_entry_t rdata_o
);
  import tsh_pkg::*;

  slot_entry_t mem [DEPTH];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the tombstone hash map. A behavioral copy of the table runs
// beside the block and predicts each result at the moment the action
// transfer is accepted. The tests cover key zero, overwrites, tombstone
// reuse, a full probe window, a long output hold-off, and random traffic
// on colliding keys under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import tsh_pkg::*;

  localparam int unsigned MAP_SLOTS   = TABLE_SLOTS_DEF;
  localparam int unsigned MAP_WINDOW  = PROBE_LIMIT_DEF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DRAIN_WAIT  = MAP_WINDOW + 100;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [14:0] FULL_MID    = 15'h4000;

  typedef struct packed {
    logic [31:0] dropped_unused;
    logic [31:0] full_failures;
    logic [15:0] tombstones;
    logic [15:0] live_entries;
    logic [31:0] upload_count;
    logic [31:0] found_handle;
    logic [1:0]  status;
  } map_result_t;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] key;
    map_result_t res;
  } expected_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [167:0] m_axis_tdata;

  slot_state_e  map_state   [MAP_SLOTS];
  logic [31:0]  map_key     [MAP_SLOTS];
  logic [31:0]  map_handle  [MAP_SLOTS];
  logic [31:0]  map_uploads [MAP_SLOTS];
  logic [31:0]  live_cnt;
  logic [31:0]  tomb_cnt;
  logic [31:0]  full_cnt;
  logic [31:0]  drop_cnt;

  expected_t    expected_results[$];
  logic [31:0]  stored_keys[$];
  logic [14:0]  cluster_mid[4];
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_req;
  int unsigned  hold_ack;
  int unsigned  hold_left;
  int unsigned  error_count;
  int unsigned  cycle_count;

  tombstone_hash_map dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic map_result_t predict_action(input logic [1:0] act,
                                                 input logic [31:0] key,
                                                 input logic [31:0] hdl);
    map_result_t r;
    logic [31:0] h;
    int unsigned s;
    int unsigned i;
    int          tomb;
    int          found;
    bit          hit;
    r = '0;
    h = (key >> 4) * HASH_MULT;
    s = h % MAP_SLOTS;
    tomb = -1;
    found = -1;
    hit = 1'b0;
    if (key == 32'd0) begin
      r.status = RES_KEY0;
    end else if (act == ACT_INSERT) begin
      for (i = 0; i < MAP_WINDOW; i++) begin
        if (map_state[s] == ST_LIVE && map_key[s] == key) begin
          map_handle[s] = hdl;
          map_uploads[s] = 32'd0;
          hit = 1'b1;
          break;
        end
        if (map_state[s] == ST_TOMB) begin
          if (tomb < 0) tomb = s;
        end else if (map_state[s] == ST_EMPTY) begin
          break;
        end
        s = (s + 1) % MAP_SLOTS;
      end
      if (hit) begin
        r.status = RES_OK;
      end else if (tomb >= 0 || i < MAP_WINDOW) begin
        if (tomb >= 0) begin
          s = tomb;
          tomb_cnt--;
        end
        map_state[s] = ST_LIVE;
        map_key[s] = key;
        map_handle[s] = hdl;
        map_uploads[s] = 32'd0;
        live_cnt++;
        r.status = RES_OK;
      end else begin
        if (full_cnt != SAT32) full_cnt++;
        r.status = RES_FULL;
      end
    end else begin
      for (i = 0; i < MAP_WINDOW; i++) begin
        if (map_state[s] == ST_LIVE && map_key[s] == key) begin
          found = s;
          break;
        end
        if (map_state[s] == ST_EMPTY) break;
        s = (s + 1) % MAP_SLOTS;
      end
      if (found < 0) begin
        r.status = RES_MISS;
      end else begin
        if (act == ACT_UPLOAD && map_uploads[found] != SAT32) map_uploads[found]++;
        r.status = RES_OK;
        r.found_handle = map_handle[found];
        r.upload_count = map_uploads[found];
        if (act == ACT_REMOVE) begin
          if (r.upload_count == 32'd0 && drop_cnt != SAT32) drop_cnt++;
          map_state[found] = ST_TOMB;
          map_handle[found] = 32'd0;
          map_uploads[found] = 32'd0;
          live_cnt--;
          tomb_cnt++;
        end
      end
    end
    r.live_entries = live_cnt[15:0];
    r.tombstones = tomb_cnt[15:0];
    r.full_failures = full_cnt;
    r.dropped_unused = drop_cnt;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic check_result(input expected_t want, input map_result_t got);
    string tag;
    tag = $sformatf("action %0d key %h", want.act, want.key);
    if (got.status !== want.res.status)
      flag_error($sformatf("%s status %h, expected %h", tag, got.status, want.res.status));
    if (got.found_handle !== want.res.found_handle)
      flag_error($sformatf("%s found_handle %h, expected %h", tag, got.found_handle,
                           want.res.found_handle));
    if (got.upload_count !== want.res.upload_count)
      flag_error($sformatf("%s upload_count %h, expected %h", tag, got.upload_count,
                           want.res.upload_count));
    if (got.live_entries !== want.res.live_entries)
      flag_error($sformatf("%s live_entries %h, expected %h", tag, got.live_entries,
                           want.res.live_entries));
    if (got.tombstones !== want.res.tombstones)
      flag_error($sformatf("%s tombstones %h, expected %h", tag, got.tombstones,
                           want.res.tombstones));
    if (got.full_failures !== want.res.full_failures)
      flag_error($sformatf("%s full_failures %h, expected %h", tag, got.full_failures,
                           want.res.full_failures));
    if (got.dropped_unused !== want.res.dropped_unused)
      flag_error($sformatf("%s dropped_unused %h, expected %h", tag, got.dropped_unused,
                           want.res.dropped_unused));
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_action(input logic [1:0] act, input logic [31:0] key,
                             input logic [31:0] hdl);
    expected_t exp;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, hdl, key, act};
    do @(posedge clk_i); while (!s_axis_tready);
    exp.act = act;
    exp.key = key;
    exp.res = predict_action(act, key, hdl);
    expected_results.push_back(exp);
    @(negedge clk_i);
  endtask

  task automatic send_random_action();
    logic [1:0]  act;
    logic [31:0] key;
    logic [31:0] hdl;
    int unsigned pick;
    bit          fresh;
    pick = $urandom_range(0, 99);
    act = (pick < 35) ? ACT_INSERT : (pick < 60) ? ACT_LOOKUP :
          (pick < 75) ? ACT_REMOVE : ACT_UPLOAD;
    pick = $urandom_range(0, 99);
    fresh = 1'b0;
    if (pick < 2) begin
      key = 32'd0;
    end else if (pick < 10) begin
      key = $urandom;
    end else if (pick < 40 || stored_keys.size() == 0) begin
      key = {13'($urandom_range(0, 8191)), cluster_mid[$urandom_range(0, 3)],
             4'($urandom_range(0, 15))};
      fresh = 1'b1;
    end else begin
      key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    end
    pick = $urandom_range(0, 9);
    hdl = (pick == 0) ? 32'd0 : (pick == 1) ? SAT32 : $urandom;
    if (fresh && act == ACT_INSERT && key != 32'd0) begin
      stored_keys.push_back(key);
      if (stored_keys.size() > 256) void'(stored_keys.pop_front());
    end
    send_action(act, key, hdl);
  endtask

  task automatic test_basic_actions();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_action(ACT_INSERT, 32'd0, 32'h1234_5678);
    send_action(ACT_LOOKUP, 32'd0, 32'd0);
    send_action(ACT_REMOVE, 32'd0, 32'd0);
    send_action(ACT_UPLOAD, 32'd0, SAT32);
    send_action(ACT_LOOKUP, SAT32, 32'd0);
    send_action(ACT_INSERT, SAT32, SAT32);
    send_action(ACT_LOOKUP, SAT32, 32'd0);
    send_action(ACT_UPLOAD, SAT32, 32'd0);
    send_action(ACT_UPLOAD, SAT32, 32'd0);
    send_action(ACT_REMOVE, SAT32, 32'd0);
    send_action(ACT_LOOKUP, SAT32, 32'd0);
    send_action(ACT_UPLOAD, SAT32, 32'd0);
    // The next three keys share one home slot.
    send_action(ACT_INSERT, 32'h0000_0011, 32'd0);
    send_action(ACT_INSERT, 32'h0000_0012, 32'hA5A5_A5A5);
    send_action(ACT_REMOVE, 32'h0000_0011, 32'd0);
    send_action(ACT_INSERT, 32'h0000_0012, 32'h5A5A_5A5A);
    send_action(ACT_UPLOAD, 32'h0000_0012, 32'd0);
    send_action(ACT_INSERT, 32'h0000_0012, 32'h0000_0001);
    send_action(ACT_LOOKUP, 32'h0000_0012, 32'd0);
    send_action(ACT_INSERT, 32'h0000_001F, SAT32);
    send_action(ACT_LOOKUP, 32'h0000_001F, 32'd0);
    send_action(ACT_REMOVE, 32'h0000_001F, 32'd0);
    send_action(ACT_REMOVE, 32'h0000_001F, 32'd0);
    send_action(ACT_INSERT, SAT32, 32'hDEAD_0001);
  endtask

  task automatic test_full_window();
    int unsigned n;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (n = 0; n < MAP_WINDOW + 3; n++)
      send_action(ACT_INSERT, {n[12:0], FULL_MID, n[3:0]}, $urandom);
    send_action(ACT_LOOKUP, {13'd600, FULL_MID, 4'd5}, 32'd0);
    send_action(ACT_UPLOAD, {13'd511, FULL_MID, 4'd15}, 32'd0);
    send_action(ACT_REMOVE, {13'd100, FULL_MID, 4'd4}, 32'd0);
    send_action(ACT_INSERT, {13'd700, FULL_MID, 4'd12}, 32'h0F0F_0F0F);
    send_action(ACT_LOOKUP, {13'd700, FULL_MID, 4'd12}, 32'd0);
    send_action(ACT_INSERT, {13'd701, FULL_MID, 4'd13}, 32'd0);
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned n;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < count; n++) send_random_action();
  endtask

  // The output stays blocked long enough for the block to stop taking input.
  task automatic test_backpressure();
    int unsigned n;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req++;
    for (n = 0; n < 12; n++) send_random_action();
  endtask

  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("result transfer with nothing expected: %h", m_axis_tdata));
      end else begin
        check_result(expected_results.pop_front(), map_result_t'(m_axis_tdata[161:0]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    for (k = 0; k < MAP_SLOTS; k++) begin
      map_state[k] = ST_EMPTY;
      map_key[k] = '0;
      map_handle[k] = '0;
      map_uploads[k] = '0;
    end
    live_cnt = '0;
    tomb_cnt = '0;
    full_cnt = '0;
    drop_cnt = '0;
    for (k = 0; k < 4; k++) cluster_mid[k] = 15'($urandom_range(0, 32767));
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_actions();
    test_full_window();
    test_random_traffic(25, 0, 0);
    test_backpressure();
    test_random_traffic(25, 48, 0);
    test_random_traffic(25, 0, 48);
    test_random_traffic(25, 15, 15);

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
